// ===== rtl/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// srv_pkg: shared types and constants for the state record validator
// Holds the header layout, the CRC-32 byte step, the register index codes
// and the newest-slot codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY   = 32'hedb8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hffff_ffff;

  // Record header layout (byte offsets)
  localparam logic [15:0] HEADER_BYTES  = 16'd16;
  localparam logic [15:0] OFF_MAGIC_END = 16'd3;
  localparam logic [15:0] OFF_VSIZE_END = 16'd7;
  localparam logic [15:0] OFF_GEN_END   = 16'd11;
  localparam logic [15:0] OFF_CRC_END   = 16'd15;
  localparam logic [15:0] OFF_CRC_FIRST = 16'd4;
  localparam logic [15:0] OFF_CRC_STOP  = 16'd12;
  localparam logic [15:0] OFFSET_LIMIT  = 16'hffff;

  localparam logic [15:0] FORMAT_VERSION = 16'd1;

  // Configuration register indexes
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_EXPECTED_MAGIC        = 1'b0;
  localparam reg_idx_t REG_EXPECTED_PAYLOAD_SIZE = 1'b1;

  // Newest slot codes
  typedef logic [1:0] newest_t;
  localparam newest_t NEWEST_NONE  = 2'd0;
  localparam newest_t NEWEST_SLOT0 = 2'd1;
  localparam newest_t NEWEST_SLOT1 = 2'd2;

  // One byte through the reflected CRC-32, unrolled over eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srv_byte_if.sv =====
// ----------------------------------------------------------------------------
// srv_byte_if: record byte channel
// One record byte per beat, with its slot and the last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface srv_byte_if;
  logic       valid;
  logic       ready;
  logic       slot_index;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output slot_index, output data_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input slot_index, input data_byte,
                  input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/srv_result_if.sv =====
// ----------------------------------------------------------------------------
// srv_result_if: check result channel
// One beat per completed record: slot, verdict, generation, newest slot.
// ----------------------------------------------------------------------------
`default_nettype none

interface srv_result_if;
  import srv_pkg::*;
  logic        valid;
  logic        ready;
  logic        checked_slot;
  logic        record_valid;
  logic [31:0] record_generation;
  newest_t     newest_slot;

  modport source (output valid, output checked_slot, output record_valid,
                  output record_generation, output newest_slot, input ready);
  modport sink   (input valid, input checked_slot, input record_valid,
                  input record_generation, input newest_slot, output ready);
endinterface

`default_nettype wire

// ===== rtl/srv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// srv_cfg_if: configuration write channel
// Register index and write data, one register write per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface srv_cfg_if;
  import srv_pkg::*;
  logic        valid;
  logic        ready;
  reg_idx_t    reg_index;
  logic [31:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/state_record_validator_core.sv =====
// ----------------------------------------------------------------------------
// state_record_validator_core: CRC-32 protected record header check
// Streams record bytes, checks magic, version, payload size and CRC-32,
// and tracks which of two slots holds the newest valid record.
//
//   channel  | dir | payload                                         | beat
//   ---------+-----+-------------------------------------------------+-----------
//   in_bus   | in  | slot_index, data_byte, last_byte                | one byte
//   out_bus  | out | checked_slot, record_valid, record_generation,  | one record
//            |     | newest_slot                                     |
//   cfg_bus  | in  | reg_index, wdata                                | one write
//
// The CRC byte step and header compares are combinational: they sit between
// the record state registers and the result register.
// A result appears on out_bus the cycle after its last byte is taken.
// in_bus stalls only while a result is held and out_bus is not ready.
// Reset (rst_n low, synchronous) clears the record state, both slots and
// both configuration registers. cfg_bus is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module state_record_validator_core #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  srv_byte_if.sink    in_bus,
  srv_result_if.source out_bus,
  srv_cfg_if.sink     cfg_bus
);
  import srv_pkg::*;

  localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);

  // Configuration registers
  logic [31:0] magic_r;
  logic [15:0] psize_r;

  // Per-record state
  logic [15:0] offset_r,  offset_nxt;
  logic [31:0] crc_r,     crc_nxt;
  logic        hmatch_r,  hmatch_nxt;
  logic [31:0] hword_r,   hword_nxt;
  logic [31:0] stored_r,  stored_nxt;
  logic [31:0] pgen_r,    pgen_nxt;

  // Slot table
  logic [1:0]  slot_ok_r, slot_ok_nxt;
  logic [31:0] slot_gen_r [2];
  logic [31:0] slot_gen_nxt [2];

  // Result register
  logic        out_valid_r;
  logic        res_slot_r;
  logic        res_valid_r;
  logic [31:0] res_gen_r;
  newest_t     res_newest_r;

  logic        in_fire;
  logic        cfg_fire;
  logic        in_span;
  logic        chk_valid;
  logic [31:0] chk_gen;
  logic [31:0] gen_diff;
  newest_t     chk_newest;
  logic [16:0] need_len;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_fire      = cfg_bus.valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
      psize_r <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_bus.reg_index)
        REG_EXPECTED_MAGIC:        magic_r <= cfg_bus.wdata;
        REG_EXPECTED_PAYLOAD_SIZE: psize_r <= cfg_bus.wdata[15:0];
        default:                   magic_r <= magic_r;
      endcase
    end
  end

  assign need_len = {1'b0, HEADER_BYTES} + {1'b0, psize_r};

  // Advance the record state by one byte
  always_comb begin
    offset_nxt = offset_r;
    crc_nxt    = crc_r;
    hmatch_nxt = hmatch_r;
    hword_nxt  = hword_r;
    stored_nxt = stored_r;
    pgen_nxt   = pgen_r;
    in_span    = 1'b0;
    if (offset_r != OFFSET_LIMIT) begin
      if (offset_r < HEADER_BYTES) begin
        hword_nxt = {in_bus.data_byte, hword_r[31:8]};
        if (offset_r == OFF_MAGIC_END && hword_nxt != magic_r) begin
          hmatch_nxt = 1'b0;
        end
        if (offset_r == OFF_VSIZE_END && hword_nxt != {psize_r, FORMAT_VERSION}) begin
          hmatch_nxt = 1'b0;
        end
        if (offset_r == OFF_GEN_END) begin
          pgen_nxt = hword_nxt;
        end
        if (offset_r == OFF_CRC_END) begin
          stored_nxt = hword_nxt;
        end
        in_span = (offset_r >= OFF_CRC_FIRST) && (offset_r < OFF_CRC_STOP);
      end else begin
        in_span = {1'b0, offset_r} < need_len;
      end
      if (in_span) begin
        crc_nxt = crc_byte(crc_r, in_bus.data_byte);
      end
      offset_nxt = offset_r + 16'd1;
    end
  end

  // Final check on the last byte
  always_comb begin
    chk_valid = hmatch_nxt
             && (psize_r <= MAX_PAYLOAD_W)
             && ({1'b0, offset_nxt} >= need_len)
             && ((crc_nxt ^ CRC_PRESET) == stored_nxt);
    chk_gen   = chk_valid ? pgen_nxt : 32'd0;

    slot_ok_nxt     = slot_ok_r;
    slot_gen_nxt[0] = slot_gen_r[0];
    slot_gen_nxt[1] = slot_gen_r[1];
    slot_ok_nxt[in_bus.slot_index]  = chk_valid;
    slot_gen_nxt[in_bus.slot_index] = chk_gen;

    // wraparound compare: slot one newer when the signed difference is positive
    gen_diff = slot_gen_nxt[1] - slot_gen_nxt[0];
    priority if (!slot_ok_nxt[0]) begin
      chk_newest = slot_ok_nxt[1] ? NEWEST_SLOT1 : NEWEST_NONE;
    end else if (!slot_ok_nxt[1]) begin
      chk_newest = NEWEST_SLOT0;
    end else begin
      chk_newest = (gen_diff != 32'd0 && !gen_diff[31]) ? NEWEST_SLOT1 : NEWEST_SLOT0;
    end
  end

  // Record state: advance on each byte, drop back to preset after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      crc_r    <= CRC_PRESET;
      hmatch_r <= 1'b1;
      hword_r  <= '0;
      stored_r <= '0;
      pgen_r   <= '0;
    end else if (in_fire) begin
      if (in_bus.last_byte) begin
        offset_r <= '0;
        crc_r    <= CRC_PRESET;
        hmatch_r <= 1'b1;
        hword_r  <= '0;
        stored_r <= '0;
        pgen_r   <= '0;
      end else begin
        offset_r <= offset_nxt;
        crc_r    <= crc_nxt;
        hmatch_r <= hmatch_nxt;
        hword_r  <= hword_nxt;
        stored_r <= stored_nxt;
        pgen_r   <= pgen_nxt;
      end
    end
  end

  // Slot table update on the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_ok_r     <= '0;
      slot_gen_r[0] <= '0;
      slot_gen_r[1] <= '0;
    end else if (in_fire && in_bus.last_byte) begin
      slot_ok_r     <= slot_ok_nxt;
      slot_gen_r[0] <= slot_gen_nxt[0];
      slot_gen_r[1] <= slot_gen_nxt[1];
    end
  end

  // Result register: load on the last byte, release when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_bus.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_bus.last_byte) begin
      res_slot_r   <= in_bus.slot_index;
      res_valid_r  <= chk_valid;
      res_gen_r    <= chk_gen;
      res_newest_r <= chk_newest;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.checked_slot      = res_slot_r;
  assign out_bus.record_valid      = res_valid_r;
  assign out_bus.record_generation = res_gen_r;
  assign out_bus.newest_slot       = res_newest_r;

  // Checks
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !in_bus.ready)
    else $error("byte taken while result held");

  a_offset_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.last_byte) |=> (offset_r == 16'd0 && crc_r == CRC_PRESET))
    else $error("record state not cleared after last byte");

  a_invalid_gen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_valid_r) |-> (res_gen_r == 32'd0))
    else $error("invalid record reports nonzero generation");

  a_invalid_not_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_valid_r) |->
      (res_newest_r != (res_slot_r ? NEWEST_SLOT1 : NEWEST_SLOT0)))
    else $error("invalid slot reported newest");

  a_newest_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_newest_r == NEWEST_NONE || res_newest_r == NEWEST_SLOT0 ||
                     res_newest_r == NEWEST_SLOT1))
    else $error("newest slot code out of range");

endmodule

`default_nettype wire
